[rtl/bist_pkg.sv]
// ----------------------------------------------------------------------------
// Set table package
// Shared widths, status codes and the word types that move between the
// controller and the row of storage cells.
// ----------------------------------------------------------------------------
package bist_pkg;

   // Width of the live count, of the capacity register and of table positions.
   localparam int COUNT_W = 5;
   localparam int VALUE_W = 32;
   localparam int STATUS_W = 3;

   // Capacity after reset.
   localparam logic [COUNT_W-1:0] CAP_RESET = 5'd16;

   // Operation codes.
   localparam logic FUNC_ADD    = 1'b0;
   localparam logic FUNC_REMOVE = 1'b1;

   // Result status codes.
   localparam logic [STATUS_W-1:0] ST_ADDED   = 3'd0;
   localparam logic [STATUS_W-1:0] ST_PRESENT = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
   localparam logic [STATUS_W-1:0] ST_REMOVED = 3'd3;
   localparam logic [STATUS_W-1:0] ST_MISSING = 3'd4;

   // Search word that walks down the row of cells, one cell per cycle.
   typedef struct packed {
      logic                      valid;
      logic signed [VALUE_W-1:0] key;
      logic                      found;
      logic [COUNT_W-1:0]        pos;
      logic signed [VALUE_W-1:0] last;
   } token_type;

   // Write broadcast from the controller to every cell.
   typedef struct packed {
      logic                      en;
      logic [COUNT_W-1:0]        pos;
      logic signed [VALUE_W-1:0] data;
   } write_type;

endpackage

[rtl/bist_if.sv]
// ----------------------------------------------------------------------------
// Set table channels
// Valid/ready channels for requests, responses and the capacity register.
// ----------------------------------------------------------------------------
interface bist_req_if;
   logic              valid;
   logic              ready;
   logic              func;
   logic signed [31:0] value;

   modport source (output valid, output func, output value, input ready);
   modport sink   (input valid, input func, input value, output ready);
endinterface

interface bist_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] status;
   logic [4:0] member_count;

   modport source (output valid, output status, output member_count, input ready);
   modport sink   (input valid, input status, input member_count, output ready);
endinterface

interface bist_csr_if;
   logic       valid;
   logic       ready;
   logic [4:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

[rtl/bist_cell.sv]
// ----------------------------------------------------------------------------
// Set table cell
// Holds one table entry. Compares the passing search word against the entry,
// records a hit and the last live entry, and hands the word to the next cell.
// ----------------------------------------------------------------------------
module bist_cell #(
   parameter int IDX = 0
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [bist_pkg::COUNT_W-1:0] count,
   input  bist_pkg::write_type         wr,
   input  bist_pkg::token_type         tok_in,
   output bist_pkg::token_type         tok_out
);
   import bist_pkg::*;

   logic signed [VALUE_W-1:0] entry_ff;
   token_type                 tok_ff;
   token_type                 tok_in_next;
   logic [31:0]               count_ext;
   logic                      live;
   logic                      is_last;
   logic                      wr_hit;

   assign count_ext = {{(32 - COUNT_W){1'b0}}, count};
   assign live      = 32'(IDX) < count_ext;
   assign is_last   = (32'(IDX) + 32'd1) == count_ext;
   assign wr_hit    = wr.en && ({{(32 - COUNT_W){1'b0}}, wr.pos} == 32'(IDX));

   // Update the search word with this cell's entry.
   always_comb begin
      tok_in_next = tok_in;
      if (!tok_in.found && live && entry_ff == tok_in.key) begin
         tok_in_next.found = 1'b1;
         tok_in_next.pos   = COUNT_W'(IDX);
      end
      if (is_last) begin
         tok_in_next.last = entry_ff;
      end
   end

   // Pass the word on; only the valid flag needs a reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else begin
         tok_ff.valid <= tok_in.valid;
      end
      tok_ff.key   <= tok_in_next.key;
      tok_ff.found <= tok_in_next.found;
      tok_ff.pos   <= tok_in_next.pos;
      tok_ff.last  <= tok_in_next.last;
   end

   // Entry storage, written by the controller's broadcast.
   always_ff @(posedge clock) begin
      if (wr_hit) begin
         entry_ff <= wr.data;
      end
   end

   assign tok_out = tok_ff;

`ifndef SYNTHESIS
   a_tok_from_prev: assert property (@(posedge clock) disable iff (reset)
      tok_ff.valid |-> $past(tok_in.valid))
      else $error("cell word appeared without an input word");
   a_found_live: assert property (@(posedge clock) disable iff (reset)
      tok_ff.valid && tok_ff.found |-> tok_ff.pos < count)
      else $error("hit position is not a live entry");
   a_no_write_in_search: assert property (@(posedge clock) disable iff (reset)
      wr_hit |-> !tok_ff.valid && !tok_in.valid)
      else $error("entry written while a search passes");
`endif

endmodule

[rtl/bounded_integer_set_table.sv]
// ----------------------------------------------------------------------------
// Bounded integer set table
// Unordered set of signed 32-bit values held in a row of search cells.
// ----------------------------------------------------------------------------
// Use: each request word on req_chan carries func (0 add, 1 remove) and a
// value. Every request gives exactly one response word on rsp_chan with a
// status (0 added, 1 already present, 2 full, 3 removed, 4 not found) and the
// member count after the operation. csr_chan writes the capacity register; it
// is always ready. It must be written only while no request is in flight, but
// the block itself does not enforce this. A request walks the row of DEPTH
// cells, one cell per cycle, into the finished-search register; from there it
// writes or swaps an entry and loads the response register once that register
// is free. The block takes no new request until the last one has loaded its
// response. The response register sits apart from the request side:
// a new request is taken while a response still waits. If the receiver
// stalls, the finished search waits at the end of the row until the response
// register frees up. Reset empties the set (count zero), sets the capacity to
// 16 and drops any request in flight; entry contents are not cleared.
// ----------------------------------------------------------------------------
module bounded_integer_set_table #(
   parameter int DEPTH = 16
) (
   input  logic       clock,
   input  logic       reset,
   bist_req_if.sink   req_chan,
   bist_rsp_if.source rsp_chan,
   bist_csr_if.sink   csr_chan
);
   import bist_pkg::*;

   // Largest count the table can ever reach.
   localparam logic [COUNT_W-1:0] DEPTH_CAP =
      (DEPTH > 31) ? 5'd31 : COUNT_W'(DEPTH);

   token_type             tok [DEPTH+1];
   write_type             wr;
   token_type             fin_tok_ff;
   logic                  fin_valid_ff;
   logic                  busy_ff;
   logic                  func_ff;
   logic [COUNT_W-1:0]    count_ff;
   logic [COUNT_W-1:0]    count_in;
   logic [COUNT_W-1:0]    cap_ff;
   logic [COUNT_W-1:0]    limit;
   logic                  rsp_valid_ff;
   logic [STATUS_W-1:0]   rsp_status_ff;
   logic [STATUS_W-1:0]   status_in;
   logic [COUNT_W-1:0]    rsp_count_ff;
   logic                  accept;
   logic                  commit;

   assign accept          = req_chan.valid && req_chan.ready;
   assign req_chan.ready  = !busy_ff;
   assign csr_chan.ready  = 1'b1;
   assign commit          = fin_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign limit           = (cap_ff < DEPTH_CAP) ? cap_ff : DEPTH_CAP;

   // Search word entering the first cell.
   always_comb begin
      tok[0].valid = accept;
      tok[0].key   = req_chan.value;
      tok[0].found = 1'b0;
      tok[0].pos   = '0;
      tok[0].last  = '0;
   end

   // Row of cells.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      bist_cell #(.IDX(i)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .count   (count_ff),
         .wr      (wr),
         .tok_in  (tok[i]),
         .tok_out (tok[i+1])
      );
   end

   // Decide the outcome of the finished search.
   always_comb begin
      wr.en     = 1'b0;
      wr.pos    = count_ff;
      wr.data   = fin_tok_ff.key;
      count_in  = count_ff;
      status_in = ST_MISSING;
      if (func_ff == FUNC_ADD) begin
         priority if (fin_tok_ff.found) begin
            status_in = ST_PRESENT;
         end else if (count_ff >= limit) begin
            status_in = ST_FULL;
         end else begin
            status_in = ST_ADDED;
            wr.en     = commit;
            count_in  = COUNT_W'(count_ff + 5'd1);
         end
      end else begin
         if (fin_tok_ff.found) begin
            status_in = ST_REMOVED;
            wr.en     = commit;
            wr.pos    = fin_tok_ff.pos;
            wr.data   = fin_tok_ff.last;
            count_in  = COUNT_W'(count_ff - 5'd1);
         end
      end
   end

   // Control: busy flag, finished word, count and capacity.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         fin_valid_ff <= 1'b0;
         count_ff     <= '0;
         cap_ff       <= CAP_RESET;
      end else begin
         if (accept) begin
            busy_ff <= 1'b1;
         end else if (commit) begin
            busy_ff <= 1'b0;
         end
         if (tok[DEPTH].valid) begin
            fin_valid_ff <= 1'b1;
         end else if (commit) begin
            fin_valid_ff <= 1'b0;
         end
         if (commit) begin
            count_ff <= count_in;
         end
         if (csr_chan.valid && csr_chan.ready) begin
            cap_ff <= csr_chan.data;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff <= req_chan.func;
      end
      if (tok[DEPTH].valid) begin
         fin_tok_ff <= tok[DEPTH];
      end
      if (commit) begin
         rsp_status_ff <= status_in;
         rsp_count_ff  <= count_in;
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status       = rsp_status_ff;
   assign rsp_chan.member_count = rsp_count_ff;

`ifndef SYNTHESIS
   a_fin_busy: assert property (@(posedge clock) disable iff (reset)
      fin_valid_ff |-> busy_ff)
      else $error("finished search without a request in flight");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_CAP)
      else $error("count beyond table depth");
   a_stall_holds_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_chan.ready |=> $stable(count_ff))
      else $error("count changed while the response stalled");
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy_ff && !req_chan.ready)
      else $error("request taken without marking busy");
`endif

endmodule

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// Set table testbench
// Runs add and remove words through the set table across several capacity
// settings. A predictor inside this module tracks the set contents, and each
// response word is checked against the oldest expected status and count.
// Both channels idle at random, and the response side holds off for a long
// stretch once so that the block fills and stalls its request side.
// ----------------------------------------------------------------------------
module testbench;
   import bist_pkg::*;

   localparam int DEPTH        = 16;
   localparam int MAX_GAP      = 18;
   localparam int HOLD_CYCLES  = 600;
   localparam int REPORT_LIMIT = 10;
   localparam int POOL_SIZE    = 24;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0]  count;
   } set_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   bist_req_if req_chan ();
   bist_rsp_if rsp_chan ();
   bist_csr_if csr_chan ();

   bounded_integer_set_table #(.DEPTH(DEPTH)) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   // Predicted contents of the set and the capacity register.
   logic signed [VALUE_W-1:0] set_values [DEPTH];
   logic [COUNT_W-1:0]        set_count;
   logic [COUNT_W-1:0]        set_capacity;

   set_result_type expected_results [$];
   int failure_count  = 0;
   bit hold_responses = 1'b0;
   bit send_quiet     = 1'b0;

   always #2 clock = ~clock;

   // Applies one add or remove to the predicted set and returns the response.
   function automatic set_result_type apply_set_op(logic op,
                                                   logic signed [VALUE_W-1:0] key);
      set_result_type     result;
      logic [COUNT_W-1:0] limit;
      int                 pos;
      int                 i;
      limit = (set_capacity < DEPTH) ? set_capacity : COUNT_W'(DEPTH);
      pos = int'(set_count);
      for (i = 0; i < set_count; i++) begin
         if (set_values[i] == key && pos == set_count) pos = i;
      end
      if (op == FUNC_ADD) begin
         if (pos < set_count) begin
            result.status = ST_PRESENT;
         end else if (set_count >= limit) begin
            result.status = ST_FULL;
         end else begin
            set_values[set_count] = key;
            set_count = set_count + 1'b1;
            result.status = ST_ADDED;
         end
      end else begin
         if (pos < set_count) begin
            set_values[pos] = set_values[set_count - 1'b1];
            set_count = set_count - 1'b1;
            result.status = ST_REMOVED;
         end else begin
            result.status = ST_MISSING;
         end
      end
      result.count = set_count;
      return result;
   endfunction

   // Idle cycles before the next word; quiet stretches have no idling at all.
   function automatic int draw_gap(inout bit quiet);
      if ($urandom_range(0, 39) == 0) quiet = ~quiet;
      return quiet ? 0 : int'($urandom_range(0, MAX_GAP));
   endfunction

   // Offers one request word and records its expected response on acceptance.
   task automatic send_word(logic op, logic signed [VALUE_W-1:0] key);
      int gap;
      gap = draw_gap(send_quiet);
      repeat (gap) begin
         @(negedge clock);
         req_chan.valid <= 1'b0;
      end
      @(negedge clock);
      req_chan.valid <= 1'b1;
      req_chan.func  <= op;
      req_chan.value <= key;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      expected_results.push_back(apply_set_op(op, key));
   endtask

   // Drops the request valid left high by the last accepted word.
   task automatic end_requests();
      @(negedge clock);
      req_chan.valid <= 1'b0;
   endtask

   // Writes the capacity register once every response has come back.
   task automatic write_capacity(logic [COUNT_W-1:0] cap);
      end_requests();
      while (expected_results.size() != 0) @(posedge clock);
      @(negedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.data  <= cap;
      do @(posedge clock); while (csr_chan.ready !== 1'b1);
      set_capacity = cap;
      @(negedge clock);
      csr_chan.valid <= 1'b0;
   endtask

   // Extreme values, duplicates, a miss, and removes that swap in the last entry.
   task automatic test_add_remove_basics();
      send_word(FUNC_ADD, 32'sh8000_0000);
      send_word(FUNC_ADD, 32'sh7FFF_FFFF);
      send_word(FUNC_ADD, 32'sd0);
      send_word(FUNC_ADD, -32'sd1);
      send_word(FUNC_ADD, 32'sh7FFF_FFFF);
      send_word(FUNC_REMOVE, 32'sd5);
      send_word(FUNC_REMOVE, 32'sh8000_0000);
      send_word(FUNC_REMOVE, -32'sd1);
      send_word(FUNC_REMOVE, -32'sd1);
   endtask

   // Capacity zero with members held, then a table filled to its depth.
   task automatic test_capacity_edges();
      int i;
      write_capacity(5'd0);
      send_word(FUNC_ADD, 32'sd9);
      send_word(FUNC_ADD, 32'sd0);
      send_word(FUNC_REMOVE, 32'sh7FFF_FFFF);
      write_capacity(5'd16);
      for (i = 1; i < DEPTH; i++) send_word(FUNC_ADD, VALUE_W'(i * 1000));
      send_word(FUNC_ADD, 32'sd200);
      send_word(FUNC_ADD, 32'sd1000);
   endtask

   // The receiver stops for a long stretch while requests keep coming.
   task automatic test_stalled_receiver();
      int i;
      fork
         begin
            hold_responses = 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_responses = 1'b0;
         end
      join_none
      for (i = 0; i < 24; i++) begin
         send_word($urandom_range(0, 1) ? FUNC_REMOVE : FUNC_ADD,
                   VALUE_W'($urandom_range(0, 20)));
      end
   endtask

   // Random words at one capacity, mostly drawn from a small pool so that
   // values repeat and the set both fills and drains.
   task automatic test_random_ops(logic [COUNT_W-1:0] cap, int add_pct, int num_words);
      logic signed [VALUE_W-1:0] pool [POOL_SIZE];
      logic signed [VALUE_W-1:0] key;
      logic                      op;
      int                        i;
      for (i = 0; i < POOL_SIZE; i++) pool[i] = $urandom;
      pool[0] = 32'sh8000_0000;
      pool[1] = 32'sh7FFF_FFFF;
      pool[2] = 32'sd0;
      pool[3] = -32'sd1;
      write_capacity(cap);
      for (i = 0; i < num_words; i++) begin
         op = ($urandom_range(0, 99) < add_pct) ? FUNC_ADD : FUNC_REMOVE;
         if ($urandom_range(0, 99) < 85) key = pool[$urandom_range(0, POOL_SIZE - 1)];
         else key = $urandom;
         send_word(op, key);
      end
   endtask

   // Response side: random stalls, the long hold-off, and the check of each word.
   initial begin : response_checker
      set_result_type seen;
      set_result_type want;
      int             stall;
      bit             quiet;
      quiet = 1'b0;
      rsp_chan.ready = 1'b0;
      while (reset) @(negedge clock);
      forever begin
         stall = draw_gap(quiet);
         repeat (stall) begin
            @(negedge clock);
            rsp_chan.ready <= 1'b0;
         end
         while (hold_responses) begin
            @(negedge clock);
            rsp_chan.ready <= 1'b0;
         end
         @(negedge clock);
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (rsp_chan.valid !== 1'b1);
         seen.status = rsp_chan.status;
         seen.count  = rsp_chan.member_count;
         if (expected_results.size() == 0) begin
            if (failure_count < REPORT_LIMIT)
               $display("unexpected response word: status %0d count %0d",
                        seen.status, seen.count);
            failure_count++;
         end else begin
            want = expected_results.pop_front();
            if (seen.status !== want.status || seen.count !== want.count) begin
               if (failure_count < REPORT_LIMIT)
                  $display({"response mismatch: expected status %0d count %0d, ",
                            "got status %0d count %0d"},
                           want.status, want.count, seen.status, seen.count);
               failure_count++;
            end
         end
      end
   end

   // Reset, then each test in turn, then drain and report.
   initial begin : stimulus
      req_chan.valid = 1'b0;
      req_chan.func  = FUNC_ADD;
      req_chan.value = '0;
      csr_chan.valid = 1'b0;
      csr_chan.data  = '0;
      set_count      = '0;
      set_capacity   = CAP_RESET;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_add_remove_basics();
      test_capacity_edges();
      test_stalled_receiver();
      test_random_ops(5'd16, 70, 220);
      test_random_ops(5'd4, 50, 220);
      test_random_ops(5'd0, 40, 220);
      test_random_ops(5'd1, 60, 220);
      test_random_ops(5'd7, 60, 220);
      test_random_ops(5'd15, 70, 220);
      test_random_ops(5'd16, 85, 220);
      test_random_ops(COUNT_W'($urandom_range(0, 16)), 50, 220);
      test_random_ops(5'd16, 20, 220);

      end_requests();
      while (expected_results.size() != 0) @(posedge clock);
      repeat (2 * DEPTH + 4) @(posedge clock);
      if (failure_count == 0) begin
         $display("bounded_integer_set_table test passed");
      end else begin
         $display("bounded_integer_set_table test failed");
      end
      $finish;
   end

   // Hard stop if the run hangs.
   initial begin : watchdog
      #4000000;
      $display("bounded_integer_set_table test failed");
      $finish;
   end

endmodule

[filelist.f]
rtl/bist_pkg.sv
rtl/bist_if.sv
rtl/bist_cell.sv
rtl/bounded_integer_set_table.sv
dv/testbench.sv
